>>> hw/rtl/bplq_pkg.sv
// ----------------------------------------------------------------------------
// bplq_pkg: shared types and constants
// Field widths, action codes and the result record of the key queue block.
// ----------------------------------------------------------------------------
package bplq_pkg;

  localparam int unsigned ACT_W       = 2;
  localparam int unsigned PIN_W       = 9;
  localparam int unsigned KEY_W       = 5;
  localparam int unsigned CODE_W      = 13;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned Q_DEPTH_DEF = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);
  localparam logic [LIMIT_W-1:0] HOLD_MAX    = '1;
  localparam logic [KEY_W-1:0]   ALL_KEYS    = 5'h1f;
  localparam logic [CODE_W-1:0]  LONG_FLAG   = 13'h1000;

  // register index, taken from paddr[2]
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    logic [CODE_W-1:0] tick_key;
    logic              pushed;
    logic [CODE_W-1:0] popped_key;
    logic              pop_valid;
    logic [CODE_W-1:0] last_long_key;
  } result_t;

endpackage

>>> hw/rtl/bplq_in_if.sv
// ----------------------------------------------------------------------------
// bplq_in_if: input channel
// Valid/ready channel carrying one action and a raw pin sample.
// ----------------------------------------------------------------------------
interface bplq_in_if import bplq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [PIN_W-1:0] pin_sample;

  modport source (output valid, output action, output pin_sample, input ready);
  modport sink   (input valid, input action, input pin_sample, output ready);
endinterface

>>> hw/rtl/bplq_out_if.sv
// ----------------------------------------------------------------------------
// bplq_out_if: result channel
// Valid/ready channel carrying one result record per input transfer.
// ----------------------------------------------------------------------------
interface bplq_out_if import bplq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] tick_key;
  logic              pushed;
  logic [CODE_W-1:0] popped_key;
  logic              pop_valid;
  logic [CODE_W-1:0] last_long_key;

  modport source (output valid, output tick_key, output pushed, output popped_key,
                  output pop_valid, output last_long_key, input ready);
  modport sink   (input valid, input tick_key, input pushed, input popped_key,
                  input pop_valid, input last_long_key, output ready);
endinterface

>>> hw/rtl/button_press_long_press_queue_unit.sv
// ----------------------------------------------------------------------------
// button_press_long_press_queue_unit: five-key scanner with long press and queue
// Each input transfer is one action: a tick with a raw pin sample (buttons on
// pins 1,3,4,5,8, active low), a pop of the oldest queued key code, or a clear
// of the detection state. Every input transfer gives exactly one result
// transfer: the tick code, whether it was queued, the popped code and whether
// the pop found an entry, and the last long-key code after the update.
// The result is captured in the result register, or in the skid stage on a stall.
// The work for an item is one pass of bitwise logic, a compare and a queue pointer
// step, so one item is taken per cycle, back to back, while the skid stage is free.
// The queue head is prefetched from its storage into a register every cycle,
// which lets a pop follow a push in the next cycle.
// Stall: a result register plus a skid stage hold up to two results; input
// ready drops only once the skid stage is occupied.
// Reset (rst_n, synchronous): clears the pressed set, hold counter, long key,
// queue pointers and output valids; the hold limit returns to 20. No clearing
// pass is needed, queue slots are only read after they are written. The hold
// limit sits at APB byte address 0; the user writes it only while idle, unenforced.
// ----------------------------------------------------------------------------
module button_press_long_press_queue_unit import bplq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bplq_in_if.sink               in_chan,
  bplq_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] limit_r;
  logic               in_ready;
  logic               acc;
  logic               push_req;
  logic               pop_req;
  result_t            res;

  // Config register: write on the access phase of an APB transfer
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? APB_DATA_W'(limit_r) : '0;

  // Accept a transfer whenever the skid stage is free
  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;
  assign pop_req       = (in_chan.action == ACT_POP);

  bplq_detect u_detect (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (acc),
    .action        (in_chan.action),
    .pin_sample    (in_chan.pin_sample),
    .limit         (limit_r),
    .tick_key      (res.tick_key),
    .push_req      (push_req),
    .last_long_key (res.last_long_key)
  );

  bplq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (acc),
    .push_req   (push_req),
    .push_key   (res.tick_key),
    .pop_req    (pop_req),
    .pushed     (res.pushed),
    .popped_key (res.popped_key),
    .pop_valid  (res.pop_valid)
  );

  // Hold the result until the receiver takes it
  bplq_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .res      (res),
    .in_ready (in_ready),
    .out_chan (out_chan)
  );

endmodule

>>> hw/rtl/bplq_detect.sv
// ----------------------------------------------------------------------------
// bplq_detect: press and long-press detection
// Holds the pressed set, hold counter and last long key; forms the tick code.
// ----------------------------------------------------------------------------
module bplq_detect import bplq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [ACT_W-1:0]   action,
  input  logic [PIN_W-1:0]   pin_sample,
  input  logic [LIMIT_W-1:0] limit,
  output logic [CODE_W-1:0]  tick_key,
  output logic               push_req,
  output logic [CODE_W-1:0]  last_long_key
);

  logic [KEY_W-1:0]   pressed_r, pressed_nxt;
  logic [LIMIT_W-1:0] hold_r, hold_nxt;
  logic [CODE_W-1:0]  long_r, long_nxt;
  logic [KEY_W-1:0]   cur;
  logic [KEY_W-1:0]   fresh;

  // remap pins 1,3,4,5,8 onto key bits 0..4, invert to active high
  assign cur   = ~{pin_sample[8], pin_sample[5], pin_sample[4], pin_sample[3], pin_sample[1]};
  assign fresh = cur & ~pressed_r;

  always_comb begin
    pressed_nxt = pressed_r;
    hold_nxt    = hold_r;
    long_nxt    = long_r;
    tick_key    = '0;
    push_req    = 1'b0;
    case (action)
      ACT_TICK: begin
        pressed_nxt = cur;
        if (hold_r > limit) begin
          long_nxt = CODE_W'(pressed_r) | LONG_FLAG;
          hold_nxt = '0;
          tick_key = CODE_W'(pressed_r) | LONG_FLAG;
        end else begin
          if ((pressed_r == cur) && (cur != '0)) begin
            if (hold_r != HOLD_MAX) begin
              hold_nxt = hold_r + 1'b1;
            end
          end else begin
            hold_nxt = '0;
          end
          tick_key = CODE_W'(fresh);
        end
        push_req = (tick_key != '0) && (tick_key != CODE_W'(ALL_KEYS));
      end
      ACT_CLEAR: begin
        pressed_nxt = '0;
        hold_nxt    = '0;
        long_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  assign last_long_key = long_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      hold_r    <= '0;
      long_r    <= '0;
    end else if (en) begin
      pressed_r <= pressed_nxt;
      hold_r    <= hold_nxt;
      long_r    <= long_nxt;
    end
  end

endmodule

>>> hw/rtl/bplq_queue.sv
// ----------------------------------------------------------------------------
// bplq_queue: ring queue of key codes
// One slot kept empty; the head entry is prefetched into a read register.
// ----------------------------------------------------------------------------
module bplq_queue import bplq_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              push_req,
  input  logic [CODE_W-1:0] push_key,
  input  logic              pop_req,
  output logic              pushed,
  output logic [CODE_W-1:0] popped_key,
  output logic              pop_valid
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] head_r;
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [PTR_W-1:0]  wr_slot, rd_slot, head_addr;
  logic              we;

  assign wr_slot   = (wr_r == LAST) ? '0 : wr_r + 1'b1;
  assign rd_slot   = (rd_r == LAST) ? '0 : rd_r + 1'b1;
  assign we        = en && push_req && (wr_slot != rd_r);
  assign pop_valid = en && pop_req && (rd_r != wr_r);
  assign pushed    = we;
  assign popped_key = pop_valid ? head_r : '0;

  assign wr_nxt    = we ? wr_slot : wr_r;
  assign rd_nxt    = pop_valid ? rd_slot : rd_r;
  assign head_addr = (rd_nxt == LAST) ? '0 : rd_nxt + 1'b1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_slot] <= push_key;
    end
    // refetch the head each cycle; forward a write to the head slot
    if (we && (wr_slot == head_addr)) begin
      head_r <= push_key;
    end else begin
      head_r <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

endmodule

>>> hw/rtl/bplq_out_buf.sv
// ----------------------------------------------------------------------------
// bplq_out_buf: result register with skid stage
// Decouples the result channel from the input so a stall costs no transfer.
// ----------------------------------------------------------------------------
module bplq_out_buf import bplq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  result_t    res,
  output logic       in_ready,
  bplq_out_if.source out_chan
);

  result_t out_r, skid_r;
  logic    out_vld_r, skid_vld_r;
  logic    drain;

  assign in_ready = !skid_vld_r;
  assign drain    = !out_vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (drain) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= acc;
      end
    end else if (acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.tick_key      = out_r.tick_key;
  assign out_chan.pushed        = out_r.pushed;
  assign out_chan.popped_key    = out_r.popped_key;
  assign out_chan.pop_valid     = out_r.pop_valid;
  assign out_chan.last_long_key = out_r.last_long_key;

endmodule

>>> hw/rtl/bplq_checker.sv
// ----------------------------------------------------------------------------
// bplq_checker: port-level checks for the key queue block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module bplq_checker import bplq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] tick_key,
  input logic              pushed,
  input logic [CODE_W-1:0] popped_key,
  input logic              pop_valid
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tick_key) && $stable(popped_key))
    else $error("stalled result changed");

  // a pop result carries no tick code
  a_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pop_valid |-> !pushed && (tick_key == '0))
    else $error("pop result with tick fields");

  // only a nonzero code other than all keys is queued
  a_push_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pushed |-> (tick_key != '0) && (tick_key != CODE_W'(ALL_KEYS))
                            && (popped_key == '0))
    else $error("illegal code queued");

endmodule

bind button_press_long_press_queue_unit bplq_checker u_bplq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .tick_key   (out_chan.tick_key),
  .pushed     (out_chan.pushed),
  .popped_key (out_chan.popped_key),
  .pop_valid  (out_chan.pop_valid)
);

>>> bench/button_press_long_press_queue_unit_test.sv
// ----------------------------------------------------------------------------
// button_press_long_press_queue_unit_test: key scanner and key queue bench
// Drives ticks, pops, clears and the spare action code into the scanner.
// Every accepted transfer is run through a local key-scan predictor, and each
// report is checked field by field in order. A short table of directed rows
// comes first. Random phases of key-hold sequences follow, each under its own
// hold limit. A long receiver hold-off fills the block so that it stalls.
// ----------------------------------------------------------------------------
module button_press_long_press_queue_unit_test;
  import bplq_pkg::*;

  localparam int unsigned        KEY_QUEUE_DEPTH = Q_DEPTH_DEF;
  localparam logic [ACT_W-1:0]   ACT_SPARE       = 2'd3;   // unused action code
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR   = {REG_LIMIT, 2'b00};
  localparam int                 CYCLE_LIMIT     = 500000;
  localparam int                 HOLD_OFF_CYCLES = 200;
  localparam int                 DRAIN_CYCLES    = 8;
  localparam int                 PHASE_ITEMS     = 90;
  localparam int                 SATURATE_TICKS  = 270;
  localparam int                 MAX_REPORTED    = 10;

  // one row of the directed table: either a hold-limit write or one transfer,
  // optionally with its report typed in by hand
  typedef struct packed {
    logic               is_limit;
    logic [LIMIT_W-1:0] limit;
    logic [ACT_W-1:0]   act;
    logic [PIN_W-1:0]   pins;
    logic               typed;
    result_t            want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bplq_in_if  in_chan ();
  bplq_out_if out_chan ();

  button_press_long_press_queue_unit #(
    .QUEUE_DEPTH(KEY_QUEUE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: hold limit, pressed sets, hold counter, long key, queue
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_now  = LIMIT_RESET;
  logic [KEY_W-1:0]   keys_down  = '0;
  logic [KEY_W-1:0]   keys_prev  = '0;
  logic [LIMIT_W-1:0] hold_ticks = '0;
  logic [CODE_W-1:0]  long_key   = '0;
  logic [CODE_W-1:0]  model_key_fifo[$];

  result_t awaited_key_reports[$];
  int      items_sent      = 0;
  int      reports_seen    = 0;
  int      mismatches      = 0;
  bit      gaps_on         = 1'b1;
  int      hold_offs_asked = 0;
  int      hold_offs_done  = 0;

  // Work out the report for one accepted transfer and advance the state.
  function automatic result_t predict_key_report(logic [ACT_W-1:0] act,
                                                 logic [PIN_W-1:0] pins);
    result_t           rep;
    logic [KEY_W-1:0]  held;
    logic [KEY_W-1:0]  fresh;
    logic [CODE_W-1:0] code;
    rep = '0;
    case (act)
      ACT_TICK: begin
        // buttons are active low; pins 1,3,4,5,8 become key bits 0..4
        held      = ~{pins[8], pins[5], pins[4], pins[3], pins[1]};
        fresh     = held & ~keys_down;
        keys_prev = keys_down;
        keys_down = held;
        if (hold_ticks > limit_now) begin
          // long press: report the previous set with the long flag, restart
          long_key   = LONG_FLAG | CODE_W'(keys_prev);
          hold_ticks = '0;
          code       = long_key;
        end else begin
          if (keys_prev == keys_down && keys_down != '0) begin
            if (hold_ticks != HOLD_MAX) hold_ticks++;
          end else begin
            hold_ticks = '0;
          end
          code = CODE_W'(fresh);
        end
        rep.tick_key = code;
        // all five keys at once is reported but never queued; drop when full
        if (code != '0 && code != CODE_W'(ALL_KEYS) &&
            model_key_fifo.size() < KEY_QUEUE_DEPTH - 1) begin
          model_key_fifo.push_back(code);
          rep.pushed = 1'b1;
        end
      end
      ACT_POP: begin
        if (model_key_fifo.size() != 0) begin
          rep.popped_key = model_key_fifo.pop_front();
          rep.pop_valid  = 1'b1;
        end
      end
      ACT_CLEAR: begin
        long_key   = '0;
        hold_ticks = '0;
        keys_down  = '0;
      end
      default: ;  // spare code: nothing changes
    endcase
    rep.last_long_key = long_key;
    return rep;
  endfunction

  // Build raw pins for a key set; unused pins carry the given noise.
  function automatic logic [PIN_W-1:0] pins_for_keys(logic [KEY_W-1:0] keys,
                                                     logic [PIN_W-1:0] noise);
    logic [PIN_W-1:0] pins;
    pins    = noise;
    pins[1] = ~keys[0];
    pins[3] = ~keys[1];
    pins[4] = ~keys[2];
    pins[5] = ~keys[3];
    pins[8] = ~keys[4];
    return pins;
  endfunction

  function automatic dir_row_t step_row(logic [ACT_W-1:0] act, logic [PIN_W-1:0] pins,
                                        logic typed = 1'b0,
                                        logic [CODE_W-1:0] tick = '0,
                                        logic pushed = 1'b0,
                                        logic [CODE_W-1:0] popped = '0,
                                        logic pop_ok = 1'b0,
                                        logic [CODE_W-1:0] long_code = '0);
    dir_row_t row;
    row                    = '0;
    row.act                = act;
    row.pins               = pins;
    row.typed              = typed;
    row.want.tick_key      = tick;
    row.want.pushed        = pushed;
    row.want.popped_key    = popped;
    row.want.pop_valid     = pop_ok;
    row.want.last_long_key = long_code;
    return row;
  endfunction

  function automatic dir_row_t limit_row(logic [LIMIT_W-1:0] value);
    dir_row_t row;
    row          = '0;
    row.is_limit = 1'b1;
    row.limit    = value;
    return row;
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("report %0d: %s", reports_seen, what);
  endfunction

  function automatic void compare_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endfunction

  // --------------------------------------------------------------------------
  // Clock, and the watchdog that ends a hung run
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: offer one transfer after a random gap; predict it once accepted
  // --------------------------------------------------------------------------
  task automatic send_item(logic [ACT_W-1:0] act, logic [PIN_W-1:0] pins,
                           logic typed = 1'b0, result_t want = '0);
    int      gap;
    int      roll;
    result_t rep;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      gap = 0;
      else if (roll < 95) gap = $urandom_range(1, 3);
      else                gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.pin_sample <= pins;
    do @(posedge clk); while (!in_chan.ready);
    // the transfer happened at this edge
    rep = predict_key_report(act, pins);
    if (typed) rep = want;
    awaited_key_reports.push_back(rep);
    items_sent++;
  endtask

  // Drop valid and hold until every awaited report has come back.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (awaited_key_reports.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge with pready high.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    limit_now  = value;
  endtask

  // Random phase: mostly press-hold-release sequences with pops mixed in,
  // the rest noise ticks, clears and the spare code.
  task automatic run_key_phase(int n_items, int pop_pct);
    int               stop_at;
    int               roll;
    int               span;
    int               len;
    logic [KEY_W-1:0] keys;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < pop_pct) begin
        send_item(ACT_POP, PIN_W'($urandom));
      end else if (roll < pop_pct + 3) begin
        send_item(ACT_CLEAR, PIN_W'($urandom));
      end else if (roll < pop_pct + 5) begin
        send_item(ACT_SPARE, PIN_W'($urandom));
      end else if (roll < pop_pct + 15) begin
        send_item(ACT_TICK, PIN_W'($urandom));
      end else begin
        // hold a key set long enough to reach past the limit now and then
        keys = KEY_W'($urandom_range(1, 31));
        span = (limit_now < 30) ? 2 * limit_now + 4 : 40;
        len  = $urandom_range(1, span);
        repeat (len) begin
          if ($urandom_range(0, 99) < 15) send_item(ACT_POP, PIN_W'($urandom));
          send_item(ACT_TICK, pins_for_keys(keys, PIN_W'($urandom)));
        end
        send_item(ACT_TICK, pins_for_keys('0, PIN_W'($urandom)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, ready stretches, and a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int roll;
    int stall;
    int run;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_offs_done != hold_offs_asked) begin
        // hold off long enough for the block to fill and stall its input
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40)      stall = 0;
        else if (roll < 95) stall = $urandom_range(1, 3);
        else                stall = $urandom_range(8, 30);
        run = (roll < 10) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each result transfer with the oldest awaited report
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      reports_seen++;
      if (awaited_key_reports.size() == 0) begin
        report_mismatch("result transfer with no report awaited");
      end else begin
        want = awaited_key_reports.pop_front();
        compare_field("tick_key", out_chan.tick_key, want.tick_key);
        compare_field("pushed", out_chan.pushed, want.pushed);
        compare_field("popped_key", out_chan.popped_key, want.popped_key);
        compare_field("pop_valid", out_chan.pop_valid, want.pop_valid);
        compare_field("last_long_key", out_chan.last_long_key, want.last_long_key);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t         dir_rows[$];
    logic [LIMIT_W-1:0] phase_limit[7];
    int               pop_share[7];
    int               ph;
    logic [KEY_W-1:0] keys;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= ACT_TICK;
    in_chan.pin_sample <= '1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset limit of 20, then under a zero limit.
    // Typed rows: pop on an empty queue, all released, all five keys at
    // once (reported, not queued), single keys at both pin extremes, the
    // spare code, and clears.
    dir_rows.push_back(step_row(ACT_POP,   9'h000, 1'b1));
    dir_rows.push_back(step_row(ACT_TICK,  9'h1ff, 1'b1));
    dir_rows.push_back(step_row(ACT_TICK,  9'h000, 1'b1, 13'h001f));
    dir_rows.push_back(step_row(ACT_TICK,  9'h000));
    dir_rows.push_back(step_row(ACT_TICK,  9'h1ff));
    dir_rows.push_back(step_row(ACT_TICK,  9'h1fd, 1'b1, 13'h0001, 1'b1));
    dir_rows.push_back(step_row(ACT_TICK,  9'h0ff, 1'b1, 13'h0010, 1'b1));
    dir_rows.push_back(step_row(ACT_TICK,  9'h13a, 1'b1));
    dir_rows.push_back(step_row(ACT_POP,   9'h1ff, 1'b1, 13'h0, 1'b0, 13'h0001, 1'b1));
    dir_rows.push_back(step_row(ACT_SPARE, 9'h000, 1'b1));
    dir_rows.push_back(step_row(ACT_TICK,  9'h1ff));
    dir_rows.push_back(step_row(ACT_CLEAR, 9'h1ff, 1'b1));
    dir_rows.push_back(step_row(ACT_POP,   9'h000, 1'b1, 13'h0, 1'b0, 13'h0010, 1'b1));
    dir_rows.push_back(step_row(ACT_POP,   9'h1ff, 1'b1));
    // zero limit: the first repeat of a held key arms the long press
    dir_rows.push_back(limit_row(8'd0));
    repeat (5) dir_rows.push_back(step_row(ACT_TICK, 9'h1ef));
    dir_rows.push_back(step_row(ACT_CLEAR, 9'h1ef, 1'b1));
    dir_rows.push_back(step_row(ACT_POP,   9'h000));
    dir_rows.push_back(step_row(ACT_POP,   9'h1ff));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_limit) begin
        wait_idle();
        write_limit(dir_rows[i].limit);
      end else begin
        send_item(dir_rows[i].act, dir_rows[i].pins, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases; the limit extremes are among them, and the top limit
    // gets a hold long enough to saturate the counter.
    phase_limit = '{8'd1, HOLD_MAX, 8'd3, 8'd0, 8'd6, LIMIT_RESET,
                    LIMIT_W'($urandom_range(1, 255))};
    pop_share   = '{30, 25, 12, 40, 20, 35, 30};
    for (ph = 0; ph < 7; ph++) begin
      wait_idle();
      write_limit(phase_limit[ph]);
      if (phase_limit[ph] == HOLD_MAX) begin
        keys = KEY_W'($urandom_range(1, 31));
        repeat (SATURATE_TICKS)
          send_item(ACT_TICK, pins_for_keys(keys, PIN_W'($urandom)));
        send_item(ACT_TICK, pins_for_keys('0, PIN_W'($urandom)));
      end
      if (ph == 2) begin
        // offer back to back while the receiver holds off
        gaps_on = 1'b0;
        hold_offs_asked++;
        run_key_phase(40, pop_share[ph]);
        gaps_on = 1'b1;
      end
      run_key_phase(PHASE_ITEMS, pop_share[ph]);
    end

    // Drain, then allow for any stray result before the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_key_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
